// ----- hw/rtl/sbpa_pkg.sv -----
// sparse bivariate polynomial adder: shared constants, codes and types
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sbpa_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int SUM_LIMIT     = 10;
  localparam int BUF_AW        = $clog2(SUM_LIMIT);
  localparam int CNT_W         = 5;
  localparam int ENTRY_W       = 32;
  localparam int KEY_W         = 16;
  localparam int COEFF_W       = 16;
  localparam int SUM_W         = 17;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_TERM  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_OVER  = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } store_cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0] coeff;
    logic [KEY_W-1:0] key;
  } sum_term_t;

endpackage

// ----- hw/rtl/sbpa_cell.sv -----
// sparse bivariate polynomial adder: one cell of a sorted term store
// depends on sbpa_pkg
`timescale 1ns / 1ps

module sbpa_cell (
  input  logic                          clk,
  input  sbpa_pkg::store_cmd_t          cmd,
  input  logic                          valid,
  input  logic [sbpa_pkg::ENTRY_W-1:0]  new_entry,
  input  logic                          ge_prev,
  input  logic [sbpa_pkg::ENTRY_W-1:0]  left_entry,
  input  logic [sbpa_pkg::ENTRY_W-1:0]  right_entry,
  output logic [sbpa_pkg::ENTRY_W-1:0]  entry_r,
  output logic                          ge
);

  logic [sbpa_pkg::ENTRY_W-1:0] entry_nxt;

  // entry stays ahead of the new term when its key is not smaller
  assign ge = valid &&
              (entry_r[sbpa_pkg::KEY_W-1:0] >= new_entry[sbpa_pkg::KEY_W-1:0]);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (!ge) begin
        entry_nxt = ge_prev ? new_entry : left_entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- hw/rtl/sbpa_store.sv -----
// sparse bivariate polynomial adder: sorted term store as a row of cells
// depends on sbpa_pkg and sbpa_cell
`timescale 1ns / 1ps

module sbpa_store #(
  parameter int MAX_TERMS = sbpa_pkg::MAX_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbpa_pkg::store_cmd_t          cmd,
  input  logic [sbpa_pkg::ENTRY_W-1:0]  new_entry,
  output logic [sbpa_pkg::ENTRY_W-1:0]  head,
  output logic                          empty,
  output logic                          full
);

  localparam int CW = $clog2(MAX_TERMS + 1);

  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic [sbpa_pkg::ENTRY_W-1:0]  entries [MAX_TERMS];
  logic [MAX_TERMS-1:0]          ge;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic                          valid;
    logic                          ge_prev;
    logic [sbpa_pkg::ENTRY_W-1:0]  left_entry;
    logic [sbpa_pkg::ENTRY_W-1:0]  right_entry;

    assign valid = count_r > CW'(i);

    if (i == 0) begin : g_head
      assign ge_prev    = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign ge_prev    = ge[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == MAX_TERMS - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    sbpa_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .valid       (valid),
      .new_entry   (new_entry),
      .ge_prev     (ge_prev),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry_r     (entries[i]),
      .ge          (ge[i])
    );
  end

  assign head  = entries[0];
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(MAX_TERMS));

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/sparse_bivariate_poly_add.sv -----
// Loads: the next request is taken in the following cycle unless the store was full.
// Full store: status result offered in the cycle after the load request.
// Finish: merge steps through the store heads, larger key first, adding equal keys and
// dropping sums that cancel, then results leave one per cycle as the output takes them.
// Reset (rst_n low, synchronous) empties both stores and returns to idle.
// depends on sbpa_pkg, sbpa_store
`timescale 1ns / 1ps

module sparse_bivariate_poly_add #(
  parameter int MAX_TERMS = sbpa_pkg::MAX_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coeff[15:0], exp_x[23:16], exp_y[31:24]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // sum_coeff[16:0], out_exp_x[24:17],
                                  // out_exp_y[32:25], term_count[37:33]
  output logic        out_tlast,  // last
  output logic [1:0]  out_tuser   // status[1:0]
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MERGE = 4'b0010,
    S_EMIT  = 4'b0100,
    S_STAT  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  sbpa_pkg::status_t               stat_r, stat_nxt;
  logic [sbpa_pkg::CNT_W-1:0]      total_r, total_nxt;
  logic [sbpa_pkg::CNT_W-1:0]      left_r, left_nxt;
  sbpa_pkg::sum_term_t             buf_r [sbpa_pkg::SUM_LIMIT];

  sbpa_pkg::action_t               action;
  logic [sbpa_pkg::COEFF_W-1:0]    coeff;
  logic [sbpa_pkg::ENTRY_W-1:0]    new_entry;
  logic                            in_acc, out_acc, coeff_nz;
  sbpa_pkg::store_cmd_t            cmd_a, cmd_b;
  logic [sbpa_pkg::ENTRY_W-1:0]    head_a, head_b;
  logic                            empty_a, empty_b, full_a, full_b;

  logic [sbpa_pkg::KEY_W-1:0]      key_a, key_b, m_key;
  logic [sbpa_pkg::SUM_W-1:0]      c_a, c_b, m_coeff;
  logic                            m_eq, m_sel_a, m_wr;
  logic [sbpa_pkg::CNT_W-1:0]      out_cnt;
  sbpa_pkg::sum_term_t             out_term;

  assign action    = sbpa_pkg::action_t'(in_tuser);
  assign coeff     = in_tdata[15:0];
  assign coeff_nz  = (coeff != '0);
  assign new_entry = {coeff, in_tdata[23:16], in_tdata[31:24]};
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // merge decision on the two store heads
  assign key_a   = head_a[sbpa_pkg::KEY_W-1:0];
  assign key_b   = head_b[sbpa_pkg::KEY_W-1:0];
  assign c_a     = {head_a[31], head_a[31:16]};
  assign c_b     = {head_b[31], head_b[31:16]};
  assign m_eq    = !empty_a && !empty_b && (key_a == key_b);
  assign m_sel_a = empty_b || (!empty_a && (key_a > key_b));
  assign m_key   = m_sel_a ? key_a : key_b;

  always_comb begin
    if (m_eq) begin
      m_coeff = c_a + c_b;
    end else if (m_sel_a) begin
      m_coeff = c_a;
    end else begin
      m_coeff = c_b;
    end
  end

  assign m_wr = (state_r == S_MERGE) && !(empty_a && empty_b) && (m_coeff != '0);

  always_comb begin
    cmd_a = '0;
    cmd_b = '0;
    if (in_acc && coeff_nz) begin
      cmd_a.ins = (action == sbpa_pkg::ACT_LOAD_A) && !full_a;
      cmd_b.ins = (action == sbpa_pkg::ACT_LOAD_B) && !full_b;
    end
    if (state_r == S_MERGE) begin
      cmd_a.pop = !empty_a && (m_eq || m_sel_a);
      cmd_b.pop = !empty_b && (m_eq || !m_sel_a);
    end
  end

  sbpa_store #(.MAX_TERMS(MAX_TERMS)) u_store_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_a),
    .new_entry (new_entry),
    .head      (head_a),
    .empty     (empty_a),
    .full      (full_a)
  );

  sbpa_store #(.MAX_TERMS(MAX_TERMS)) u_store_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_b),
    .new_entry (new_entry),
    .head      (head_b),
    .empty     (empty_b),
    .full      (full_b)
  );

  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    total_nxt = total_r;
    left_nxt  = left_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (action)
            sbpa_pkg::ACT_LOAD_A: begin
              if (coeff_nz && full_a) begin
                stat_nxt  = sbpa_pkg::STS_FULL;
                state_nxt = S_STAT;
              end
            end
            sbpa_pkg::ACT_LOAD_B: begin
              if (coeff_nz && full_b) begin
                stat_nxt  = sbpa_pkg::STS_FULL;
                state_nxt = S_STAT;
              end
            end
            sbpa_pkg::ACT_FINISH: begin
              total_nxt = '0;
              state_nxt = S_MERGE;
            end
            default: begin
            end
          endcase
        end
      end
      S_MERGE: begin
        if (empty_a && empty_b) begin
          if (total_r == '0) begin
            stat_nxt  = sbpa_pkg::STS_EMPTY;
            state_nxt = S_STAT;
          end else if (total_r > sbpa_pkg::CNT_W'(sbpa_pkg::SUM_LIMIT)) begin
            stat_nxt  = sbpa_pkg::STS_OVER;
            state_nxt = S_STAT;
          end else begin
            stat_nxt  = sbpa_pkg::STS_TERM;
            left_nxt  = total_r;
            state_nxt = S_EMIT;
          end
        end else if (m_wr && (total_r != sbpa_pkg::CNT_SAT)) begin
          total_nxt = total_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          left_nxt = left_r - 1'b1;
          if (left_r == sbpa_pkg::CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= sbpa_pkg::STS_TERM;
      total_r <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
      total_r <= total_nxt;
      left_r  <= left_nxt;
    end
  end

  // sum buffer: appended during merge, shifted toward the head while emitting
  always_ff @(posedge clk) begin
    if (m_wr && (total_r < sbpa_pkg::CNT_W'(sbpa_pkg::SUM_LIMIT))) begin
      buf_r[total_r[sbpa_pkg::BUF_AW-1:0]] <= '{coeff: m_coeff, key: m_key};
    end else if ((state_r == S_EMIT) && out_acc) begin
      for (int i = 0; i < sbpa_pkg::SUM_LIMIT - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  always_comb begin
    out_term = '0;
    out_cnt  = '0;
    if (state_r == S_EMIT) begin
      out_term = buf_r[0];
      out_cnt  = total_r;
    end else if (stat_r == sbpa_pkg::STS_OVER) begin
      out_cnt  = total_r;
    end
  end

  assign out_tvalid = (state_r == S_EMIT) || (state_r == S_STAT);
  assign out_tdata  = {2'b00, out_cnt, out_term.key[7:0], out_term.key[15:8],
                       out_term.coeff};
  assign out_tlast  = (state_r == S_STAT) || (left_r == sbpa_pkg::CNT_W'(1));
  assign out_tuser  = stat_r;

endmodule

// ----- sim/tb_top.sv -----
// testbench for sparse_bivariate_poly_add: loads two sparse polynomials, finishes
// and checks each sum term or status against an internal merge predictor
// depends on sbpa_pkg and sparse_bivariate_poly_add
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_DEPTH = sbpa_pkg::MAX_TERMS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    sbpa_pkg::action_t act;
    logic [15:0]       coeff;
    logic [7:0]        exp_x;
    logic [7:0]        exp_y;
  } poly_req_t;

  typedef struct {
    logic [16:0]       coeff;
    logic [7:0]        exp_x;
    logic [7:0]        exp_y;
    logic [4:0]        term_count;
    logic              is_last;
    sbpa_pkg::status_t status;
  } sum_term_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  poly_req_t     pending_q[$];
  sum_term_res_t sum_terms_q[$];
  poly_req_t     drv_req;
  sum_term_res_t got_res;

  logic [31:0] poly_store[2][STORE_DEPTH];
  int          poly_cnt[2];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued_cnt = 0;
  int taken_cnt = 0;
  int gen_items = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  sparse_bivariate_poly_add dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [16:0] entry_coeff(logic [31:0] entry);
    return $signed({entry[31], entry[31:16]});
  endfunction

  task automatic push_sum_term(logic [16:0] coeff, logic [15:0] key, int total,
                               logic is_last, sbpa_pkg::status_t status);
    sum_term_res_t r;
    r.coeff      = coeff;
    r.exp_x      = key[15:8];
    r.exp_y      = key[7:0];
    r.term_count = (total > 31) ? 5'd31 : total[4:0];
    r.is_last    = is_last;
    r.status     = status;
    sum_terms_q.push_back(r);
  endtask

  // sorted insert per store, merge of both stores on finish
  task automatic apply_poly_request(sbpa_pkg::action_t act, logic [15:0] coeff,
                                    logic [7:0] exp_x, logic [7:0] exp_y);
    int                 side;
    int                 pos;
    int                 i;
    int                 j;
    int                 total;
    logic [31:0]        entry;
    logic [15:0]        key;
    logic [15:0]        key_a;
    logic [15:0]        key_b;
    logic signed [16:0] c;
    logic signed [16:0] sum_c[2*STORE_DEPTH];
    logic [15:0]        sum_k[2*STORE_DEPTH];
    case (act)
      sbpa_pkg::ACT_LOAD_A, sbpa_pkg::ACT_LOAD_B: begin
        side  = (act == sbpa_pkg::ACT_LOAD_A) ? 0 : 1;
        entry = {coeff, exp_x, exp_y};
        if (coeff != 16'd0) begin
          if (poly_cnt[side] >= STORE_DEPTH) begin
            push_sum_term('0, '0, 0, 1'b1, sbpa_pkg::STS_FULL);
          end else begin
            pos = 0;
            while (pos < poly_cnt[side] && poly_store[side][pos][15:0] >= entry[15:0])
              pos++;
            for (i = poly_cnt[side]; i > pos; i--)
              poly_store[side][i] = poly_store[side][i-1];
            poly_store[side][pos] = entry;
            poly_cnt[side]++;
          end
        end
      end
      sbpa_pkg::ACT_FINISH: begin
        i = 0;
        j = 0;
        total = 0;
        while (i < poly_cnt[0] || j < poly_cnt[1]) begin
          key_a = (i < poly_cnt[0]) ? poly_store[0][i][15:0] : 16'd0;
          key_b = (j < poly_cnt[1]) ? poly_store[1][j][15:0] : 16'd0;
          if (i < poly_cnt[0] && j < poly_cnt[1] && key_a == key_b) begin
            c   = entry_coeff(poly_store[0][i]) + entry_coeff(poly_store[1][j]);
            key = key_a;
            i++;
            j++;
          end else if (j >= poly_cnt[1] || (i < poly_cnt[0] && key_a > key_b)) begin
            c   = entry_coeff(poly_store[0][i]);
            key = key_a;
            i++;
          end else begin
            c   = entry_coeff(poly_store[1][j]);
            key = key_b;
            j++;
          end
          if (c != 17'sd0) begin
            sum_c[total] = c;
            sum_k[total] = key;
            total++;
          end
        end
        poly_cnt[0] = 0;
        poly_cnt[1] = 0;
        if (total == 0) begin
          push_sum_term('0, '0, 0, 1'b1, sbpa_pkg::STS_EMPTY);
        end else if (total > sbpa_pkg::SUM_LIMIT) begin
          push_sum_term('0, '0, total, 1'b1, sbpa_pkg::STS_OVER);
        end else begin
          for (i = 0; i < total; i++)
            push_sum_term(sum_c[i], sum_k[i], total, i == total - 1,
                          sbpa_pkg::STS_TERM);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_poly_request(sbpa_pkg::action_t'(in_tuser), in_tdata[15:0],
                           in_tdata[23:16], in_tdata[31:24]);
        taken_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {drv_req.exp_y, drv_req.exp_x, drv_req.coeff};
          in_tuser  <= drv_req.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sum_terms_q.size() == 0) begin
          $error("result with no request pending: tdata %0h tuser %0h",
                 out_tdata, out_tuser);
          mismatch_cnt++;
        end else begin
          got_res = sum_terms_q.pop_front();
          check_field("sum_coeff", 32'(got_res.coeff), 32'(out_tdata[16:0]));
          check_field("out_exp_x", 32'(got_res.exp_x), 32'(out_tdata[24:17]));
          check_field("out_exp_y", 32'(got_res.exp_y), 32'(out_tdata[32:25]));
          check_field("term_count", 32'(got_res.term_count), 32'(out_tdata[37:33]));
          check_field("last", 32'(got_res.is_last), 32'(out_tlast));
          check_field("status", 32'(got_res.status), 32'(out_tuser));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_req(sbpa_pkg::action_t act, logic [15:0] coeff,
                          logic [7:0] exp_x, logic [7:0] exp_y);
    poly_req_t r;
    r.act   = act;
    r.coeff = coeff;
    r.exp_x = exp_x;
    r.exp_y = exp_y;
    pending_q.push_back(r);
    queued_cnt++;
    if (act != sbpa_pkg::ACT_NONE)
      gen_items++;
  endtask

  function automatic logic [15:0] rand_coeff();
    int r;
    r = $urandom_range(99);
    if (r < 4)
      return 16'h0000;
    else if (r < 8)
      return 16'h7FFF;
    else if (r < 12)
      return 16'h8000;
    else if (r < 30)
      return 16'($signed($urandom_range(20)) - 10);
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] rand_exp(int span);
    int r;
    r = $urandom_range(99);
    if (r < 5)
      return 8'd0;
    else if (r < 10)
      return 8'd255;
    return 8'($urandom_range(span));
  endfunction

  // two polynomials loaded in random interleave, then finish
  task automatic gen_poly(int na, int nb, int span);
    logic [15:0] a_coeff[24];
    logic [15:0] a_key[24];
    logic [15:0] b_coeff[24];
    logic [15:0] b_key[24];
    int          k;
    int          m;
    int          ia;
    int          ib;
    for (k = 0; k < na; k++) begin
      a_coeff[k] = rand_coeff();
      a_key[k]   = {rand_exp(span), rand_exp(span)};
    end
    for (k = 0; k < nb; k++) begin
      if (na > 0 && $urandom_range(99) < 35) begin
        m = $urandom_range(na - 1);
        b_key[k]   = a_key[m];
        b_coeff[k] = $urandom_range(1) ? -a_coeff[m] : rand_coeff();
      end else begin
        b_coeff[k] = rand_coeff();
        b_key[k]   = {rand_exp(span), rand_exp(span)};
      end
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(1))) begin
        push_req(sbpa_pkg::ACT_LOAD_A, a_coeff[ia], a_key[ia][15:8], a_key[ia][7:0]);
        ia++;
      end else begin
        push_req(sbpa_pkg::ACT_LOAD_B, b_coeff[ib], b_key[ib][15:8], b_key[ib][7:0]);
        ib++;
      end
    end
    push_req(sbpa_pkg::ACT_FINISH, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic gen_random(int n_items);
    int target;
    int r;
    int k;
    int spans[4];
    spans = '{1, 3, 15, 255};
    target = gen_items + n_items;
    while (gen_items < target) begin
      r = $urandom_range(99);
      if (r < 72) begin
        gen_poly($urandom_range(7), $urandom_range(7), spans[$urandom_range(3)]);
      end else if (r < 82) begin
        gen_poly($urandom_range(14, 18),
                 $urandom_range(1) ? $urandom_range(16, 18) : $urandom_range(18), 255);
      end else begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          push_req(sbpa_pkg::action_t'($urandom_range(3)), 16'($urandom),
                   8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (taken_cnt != queued_cnt || sum_terms_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    poly_cnt[0] = 0;
    poly_cnt[1] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty sum, ignored requests
    push_req(sbpa_pkg::ACT_FINISH, 16'h0000, 8'd0, 8'd0);
    push_req(sbpa_pkg::ACT_LOAD_A, 16'h0000, 8'd255, 8'd255);
    push_req(sbpa_pkg::ACT_NONE, 16'hFFFF, 8'd255, 8'd255);
    // extreme coefficients and exponents, equal pairs within a store, cancel
    push_req(sbpa_pkg::ACT_LOAD_A, 16'h7FFF, 8'd255, 8'd255);
    push_req(sbpa_pkg::ACT_LOAD_A, 16'h8000, 8'd0, 8'd0);
    push_req(sbpa_pkg::ACT_LOAD_B, 16'h7FFF, 8'd255, 8'd255);
    push_req(sbpa_pkg::ACT_LOAD_B, 16'h8000, 8'd0, 8'd0);
    push_req(sbpa_pkg::ACT_LOAD_A, 16'd5, 8'd3, 8'd4);
    push_req(sbpa_pkg::ACT_LOAD_B, -16'sd5, 8'd3, 8'd4);
    push_req(sbpa_pkg::ACT_LOAD_A, 16'd7, 8'd3, 8'd4);
    push_req(sbpa_pkg::ACT_LOAD_A, 16'd9, 8'd3, 8'd4);
    push_req(sbpa_pkg::ACT_LOAD_B, 16'd1, 8'd3, 8'd4);
    push_req(sbpa_pkg::ACT_LOAD_A, -16'sd1, 8'd3, 8'd5);
    push_req(sbpa_pkg::ACT_FINISH, 16'h0000, 8'd0, 8'd0);
    // everything cancels
    push_req(sbpa_pkg::ACT_LOAD_A, 16'd100, 8'd1, 8'd1);
    push_req(sbpa_pkg::ACT_LOAD_B, -16'sd100, 8'd1, 8'd1);
    push_req(sbpa_pkg::ACT_FINISH, 16'h0000, 8'd0, 8'd0);
    // one side empty
    push_req(sbpa_pkg::ACT_LOAD_B, 16'd3, 8'd0, 8'd255);
    push_req(sbpa_pkg::ACT_LOAD_B, -16'sd2, 8'd255, 8'd0);
    push_req(sbpa_pkg::ACT_FINISH, 16'h0000, 8'd0, 8'd0);
    push_req(sbpa_pkg::ACT_LOAD_A, 16'd1, 8'd128, 8'd128);
    push_req(sbpa_pkg::ACT_FINISH, 16'h0000, 8'd0, 8'd0);

    gen_random(70);
    wait_drained();

    send_idle_pct = 60;
    recv_stall_pct = 0;
    gen_random(70);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 60;
    gen_random(70);
    wait_drained();

    send_idle_pct = 37;
    recv_stall_pct = 37;
    gen_random(70);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sum_terms_q.size() != 0) begin
      $error("%0d results never arrived", sum_terms_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
